// ===== sv/sss_pkg.sv =====
// Shared types, codes and lookup tables of the selective state-space scan.
// Used by every module of the block; depends on nothing.
package sss_pkg;

    // Number of hidden state elements held
    localparam int STATE_SIZE = 16;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_STEP_BIAS    = 3'd0;
    localparam logic [2:0] REG_SKIP_GAIN    = 3'd1;
    localparam logic [2:0] REG_SKIP_ON      = 3'd2;
    localparam logic [2:0] REG_SOFTPLUS_ON  = 3'd3;
    localparam logic [2:0] REG_GATE_ON      = 3'd4;
    localparam logic [2:0] REG_INPUT_COEF_B = 3'd5;
    localparam logic [2:0] REG_INPUT_COEF_C = 3'd6;

    typedef struct packed {
        logic signed [15:0] step_bias;
        logic signed [15:0] skip_gain;
        logic               skip_on;
        logic               softplus_on;
        logic               gate_on;
        logic               input_coef_b;
        logic               input_coef_c;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DT, ST_MA, ST_MQ, ST_EXP, ST_DB, ST_DBU, ST_EX, ST_XN,
        ST_XC, ST_ACC, ST_SKP, ST_YS, ST_SIG, ST_SILU, ST_GATE, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_DT, OP_MA, OP_MQ, OP_EXP, OP_DB, OP_DBU, OP_EX, OP_XN,
        OP_XC, OP_ACC, OP_SKP, OP_YS, OP_SIG, OP_SILU, OP_GATE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_ok;
        logic in_last;
        logic last;
        logic gate_on;
        logic out_ready;
    } status_t;

    // Softplus at the whole numbers -8.0 .. 8.0, Q8.8
    function automatic logic [16:0] softplus_tab(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd0;
            5'd2:    r = 17'd1;
            5'd3:    r = 17'd2;
            5'd4:    r = 17'd5;
            5'd5:    r = 17'd12;
            5'd6:    r = 17'd32;
            5'd7:    r = 17'd80;
            5'd8:    r = 17'd177;
            5'd9:    r = 17'd336;
            5'd10:   r = 17'd544;
            5'd11:   r = 17'd780;
            5'd12:   r = 17'd1029;
            5'd13:   r = 17'd1282;
            5'd14:   r = 17'd1537;
            5'd15:   r = 17'd1792;
            default: r = 17'd2048;
        endcase
        return r;
    endfunction

    // Sigmoid at the whole numbers -8.0 .. 8.0, Q0.16
    function automatic logic [16:0] sigmoid_tab(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd22;
            5'd1:    r = 17'd60;
            5'd2:    r = 17'd162;
            5'd3:    r = 17'd439;
            5'd4:    r = 17'd1179;
            5'd5:    r = 17'd3108;
            5'd6:    r = 17'd7812;
            5'd7:    r = 17'd17625;
            5'd8:    r = 17'd32768;
            5'd9:    r = 17'd47911;
            5'd10:   r = 17'd57724;
            5'd11:   r = 17'd62428;
            5'd12:   r = 17'd64357;
            5'd13:   r = 17'd65097;
            5'd14:   r = 17'd65374;
            5'd15:   r = 17'd65476;
            default: r = 17'd65514;
        endcase
        return r;
    endfunction

    // 2^f at sixteenths of one, Q16.16
    function automatic logic [17:0] pow2_tab(input logic [4:0] i);
        logic [17:0] r;
        case (i)
            5'd0:    r = 18'd65536;
            5'd1:    r = 18'd68438;
            5'd2:    r = 18'd71468;
            5'd3:    r = 18'd74632;
            5'd4:    r = 18'd77936;
            5'd5:    r = 18'd81386;
            5'd6:    r = 18'd84990;
            5'd7:    r = 18'd88752;
            5'd8:    r = 18'd92682;
            5'd9:    r = 18'd96785;
            5'd10:   r = 18'd101070;
            5'd11:   r = 18'd105545;
            5'd12:   r = 18'd110218;
            5'd13:   r = 18'd115098;
            5'd14:   r = 18'd120194;
            5'd15:   r = 18'd125515;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/sss_cfg.sv =====
// Configuration registers of the selective state-space scan.
// Depends on sss_pkg for the register indexes and the cfg_t bundle.
module sss_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output sss_pkg::cfg_t      cfg
);

    sss_pkg::cfg_t cfg_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the index and hold the written value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sss_pkg::REG_STEP_BIAS:    cfg_reg.step_bias    <= $signed(cfg_data);
                sss_pkg::REG_SKIP_GAIN:    cfg_reg.skip_gain    <= $signed(cfg_data);
                sss_pkg::REG_SKIP_ON:      cfg_reg.skip_on      <= cfg_data[0];
                sss_pkg::REG_SOFTPLUS_ON:  cfg_reg.softplus_on  <= cfg_data[0];
                sss_pkg::REG_GATE_ON:      cfg_reg.gate_on      <= cfg_data[0];
                sss_pkg::REG_INPUT_COEF_B: cfg_reg.input_coef_b <= cfg_data[0];
                sss_pkg::REG_INPUT_COEF_C: cfg_reg.input_coef_c <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

endmodule

// ===== sv/sss_ctrl.sv =====
// Sequencing state machine of the selective state-space scan.
// Depends on sss_pkg for state, command and status types.
module sss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        kind,
    input  sss_pkg::status_t  status,
    output logic              in_stall,
    output sss_pkg::cmd_t     cmd
);

    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                if (in_valid && kind == sss_pkg::KIND_SCAN)
                begin
                    if (status.in_ok)
                        state_next = sss_pkg::ST_DT;
                    else if (status.in_last)
                        state_next = sss_pkg::ST_SKP;
                end
            end
            sss_pkg::ST_DT:   state_next = sss_pkg::ST_MA;
            sss_pkg::ST_MA:   state_next = sss_pkg::ST_MQ;
            sss_pkg::ST_MQ:   state_next = sss_pkg::ST_EXP;
            sss_pkg::ST_EXP:  state_next = sss_pkg::ST_DB;
            sss_pkg::ST_DB:   state_next = sss_pkg::ST_DBU;
            sss_pkg::ST_DBU:  state_next = sss_pkg::ST_EX;
            sss_pkg::ST_EX:   state_next = sss_pkg::ST_XN;
            sss_pkg::ST_XN:   state_next = sss_pkg::ST_XC;
            sss_pkg::ST_XC:   state_next = sss_pkg::ST_ACC;
            sss_pkg::ST_ACC:
                state_next = status.last ? sss_pkg::ST_SKP : sss_pkg::ST_IDLE;
            sss_pkg::ST_SKP:  state_next = sss_pkg::ST_YS;
            sss_pkg::ST_YS:
                state_next = status.gate_on ? sss_pkg::ST_SIG : sss_pkg::ST_EMIT;
            sss_pkg::ST_SIG:  state_next = sss_pkg::ST_SILU;
            sss_pkg::ST_SILU: state_next = sss_pkg::ST_GATE;
            sss_pkg::ST_GATE: state_next = sss_pkg::ST_EMIT;
            sss_pkg::ST_EMIT:
            begin
                if (status.out_ready)
                    state_next = sss_pkg::ST_IDLE;
            end
            default:          state_next = sss_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall = (state_reg != sss_pkg::ST_IDLE);
        cmd.emit = (state_reg == sss_pkg::ST_EMIT);
        case (state_reg)
            sss_pkg::ST_DT:   cmd.op = sss_pkg::OP_DT;
            sss_pkg::ST_MA:   cmd.op = sss_pkg::OP_MA;
            sss_pkg::ST_MQ:   cmd.op = sss_pkg::OP_MQ;
            sss_pkg::ST_EXP:  cmd.op = sss_pkg::OP_EXP;
            sss_pkg::ST_DB:   cmd.op = sss_pkg::OP_DB;
            sss_pkg::ST_DBU:  cmd.op = sss_pkg::OP_DBU;
            sss_pkg::ST_EX:   cmd.op = sss_pkg::OP_EX;
            sss_pkg::ST_XN:   cmd.op = sss_pkg::OP_XN;
            sss_pkg::ST_XC:   cmd.op = sss_pkg::OP_XC;
            sss_pkg::ST_ACC:  cmd.op = sss_pkg::OP_ACC;
            sss_pkg::ST_SKP:  cmd.op = sss_pkg::OP_SKP;
            sss_pkg::ST_YS:   cmd.op = sss_pkg::OP_YS;
            sss_pkg::ST_SIG:  cmd.op = sss_pkg::OP_SIG;
            sss_pkg::ST_SILU: cmd.op = sss_pkg::OP_SILU;
            sss_pkg::ST_GATE: cmd.op = sss_pkg::OP_GATE;
            default:          cmd.op = sss_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== sv/sss_dp.sv =====
// Datapath of the selective state-space scan: state, tables, arithmetic
// steps and the output register. Depends on sss_pkg.
module sss_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sss_pkg::cfg_t       cfg,
    input  sss_pkg::cmd_t       cmd,
    input  logic                in_acc,
    input  logic [1:0]          kind,
    input  logic [3:0]          state_index,
    input  logic signed [15:0]  u_sample,
    input  logic signed [15:0]  step_size,
    input  logic signed [15:0]  gate_value,
    input  logic signed [15:0]  coef_a,
    input  logic signed [15:0]  coef_b,
    input  logic signed [15:0]  coef_c,
    input  logic                step_last,
    output sss_pkg::status_t    status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_value
);

    // Latched item
    logic [3:0]         idx_reg;
    logic signed [15:0] u_reg, step_reg, z_reg, cb_reg, cc_reg;
    logic               last_reg;

    // Stores
    logic signed [15:0] a_tab [sss_pkg::STATE_SIZE];
    logic signed [15:0] b_tab [sss_pkg::STATE_SIZE];
    logic signed [15:0] c_tab [sss_pkg::STATE_SIZE];
    logic signed [31:0] hs_reg [sss_pkg::STATE_SIZE];
    logic signed [39:0] sum_reg;

    // Step registers
    logic signed [15:0] dt_reg, av_reg, bv_reg, cv_reg;
    logic signed [31:0] p_reg, dtb_reg, x_reg, gu_reg, y_reg;
    logic signed [32:0] q_reg;
    logic [31:0]        e_reg;
    logic signed [39:0] dbu_reg, xc_reg;
    logic signed [47:0] ex_reg;
    logic [16:0]        sg_reg;
    logic signed [16:0] silu_reg;
    logic signed [31:0] out_value_reg;
    logic               out_valid_reg;

    // Step results
    logic signed [15:0] dt_next;
    logic signed [31:0] p_next, dtb_next, x_next, gu_next, ys_next, gate_next;
    logic signed [32:0] q_next;
    logic [31:0]        e_next;
    logic signed [39:0] dbu_next, xc_next, acc_next;
    logic signed [47:0] ex_next;
    logic [16:0]        sg_next;
    logic signed [16:0] silu_next;

    logic signed [16:0] bsum;
    logic signed [15:0] dt_sat;
    logic [11:0]        sp_off, sg_off;
    logic [16:0]        sp_val;
    logic signed [49:0] qp, qr;
    logic signed [16:0] ip;
    logic [4:0]         ei, ns;
    logic [17:0]        m_lo, m_hi, m_val;
    logic [29:0]        m_prod;
    logic [47:0]        m_left, m_right;
    logic signed [64:0] exr;
    logic signed [47:0] dbr, xcr;
    logic signed [48:0] xs;
    logic signed [40:0] as_sum, ys_sum;
    logic signed [34:0] slr;
    logic signed [49:0] gtr;
    logic               out_ready;
    logic               in_ok;

    // Piecewise linear step between two rising table points
    function automatic logic [16:0] interp17(input logic [16:0] lo,
                                             input logic [16:0] hi,
                                             input logic [7:0]  fr);
        logic [24:0] d;
        d = 25'(hi - lo) * 25'(fr) + 25'd128;
        return lo + d[24:8];
    endfunction

    assign in_ok     = (int'(state_index) < sss_pkg::STATE_SIZE);
    assign out_ready = !out_valid_reg || !out_stall;

    assign status.in_ok     = in_ok;
    assign status.in_last   = step_last;
    assign status.last      = last_reg;
    assign status.gate_on   = cfg.gate_on;
    assign status.out_ready = out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    // Step size with bias, saturation and optional softplus
    always_comb
    begin
        bsum = 17'(step_reg) + 17'(cfg.step_bias);
        if (bsum > 17'sd32767)
            dt_sat = 16'sh7FFF;
        else if (bsum < -17'sd32768)
            dt_sat = 16'sh8000;
        else
            dt_sat = bsum[15:0];
        sp_off = 12'(dt_sat + 16'sd2048);
        sp_val = interp17(sss_pkg::softplus_tab({1'b0, sp_off[11:8]}),
                          sss_pkg::softplus_tab({1'b0, sp_off[11:8]} + 5'd1),
                          sp_off[7:0]);
        if (!cfg.softplus_on || dt_sat >= 16'sd2048)
            dt_next = dt_sat;
        else if (dt_sat < -16'sd2048)
            dt_next = '0;
        else
            dt_next = $signed(sp_val[15:0]);
    end

    // dt*A and its base-2 exponent
    always_comb
    begin
        p_next = dt_reg * av_reg;
        qp     = p_reg * 50'sd94548;
        qr     = qp + 50'sd32768;
        q_next = 33'(qr >>> 16);
    end

    // 2^q: fraction from the table, whole part as a rounding shift
    always_comb
    begin
        ip      = $signed(q_reg[32:16]);
        ei      = {1'b0, q_reg[15:12]};
        m_lo    = sss_pkg::pow2_tab(ei);
        m_hi    = sss_pkg::pow2_tab(ei + 5'd1);
        m_prod  = 30'(m_hi - m_lo) * 30'(q_reg[11:0]) + 30'd2048;
        m_val   = m_lo + m_prod[29:12];
        ns      = 5'(-ip);
        m_left  = {30'd0, m_val} << ip[3:0];
        m_right = ({30'd0, m_val} + (48'd1 << (ns - 5'd1))) >> ns;
        if (ip >= 17'sd15)
            e_next = 32'h7FFF_FFFF;
        else if (ip < -17'sd20)
            e_next = '0;
        else if (ip >= 17'sd0)
            e_next = (m_left > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_left[31:0];
        else
            e_next = m_right[31:0];
    end

    // State update and output accumulation
    always_comb
    begin
        dtb_next = dt_reg * bv_reg;
        dbr      = dtb_reg * u_reg;
        dbu_next = 40'((dbr + 48'sd128) >>> 8);
        exr      = $signed({33'd0, e_reg}) * hs_reg[idx_reg];
        ex_next  = 48'((exr + 65'sd32768) >>> 16);
        xs       = ex_reg + dbu_reg;
        if (xs > 49'sd2147483647)
            x_next = 32'sh7FFF_FFFF;
        else if (xs < -49'sd2147483648)
            x_next = 32'sh8000_0000;
        else
            x_next = xs[31:0];
        xcr      = x_reg * cv_reg;
        xc_next  = 40'((xcr + 48'sd128) >>> 8);
        as_sum   = sum_reg + xc_reg;
        if (as_sum > 41'sd549755813887)
            acc_next = 40'sh7F_FFFF_FFFF;
        else if (as_sum < -41'sd549755813888)
            acc_next = 40'sh80_0000_0000;
        else
            acc_next = as_sum[39:0];
    end

    // Output with feedthrough and gate
    always_comb
    begin
        gu_next = cfg.skip_on ? (cfg.skip_gain * u_reg) : 32'sd0;
        ys_sum  = sum_reg + gu_reg;
        if (ys_sum > 41'sd2147483647)
            ys_next = 32'sh7FFF_FFFF;
        else if (ys_sum < -41'sd2147483648)
            ys_next = 32'sh8000_0000;
        else
            ys_next = ys_sum[31:0];
        sg_off = 12'(z_reg + 16'sd2048);
        if (z_reg < -16'sd2048)
            sg_next = '0;
        else if (z_reg >= 16'sd2048)
            sg_next = 17'd65536;
        else
            sg_next = interp17(sss_pkg::sigmoid_tab({1'b0, sg_off[11:8]}),
                               sss_pkg::sigmoid_tab({1'b0, sg_off[11:8]} + 5'd1),
                               sg_off[7:0]);
        slr       = z_reg * $signed({1'b0, sg_reg});
        silu_next = 17'((slr + 35'sd32768) >>> 16);
        gtr       = y_reg * silu_reg;
        gtr       = (gtr + 50'sd128) >>> 8;
        if (gtr > 50'sd2147483647)
            gate_next = 32'sh7FFF_FFFF;
        else if (gtr < -50'sd2147483648)
            gate_next = 32'sh8000_0000;
        else
            gate_next = gtr[31:0];
    end

    // Latch the item and write the coefficient tables
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            idx_reg  <= state_index;
            u_reg    <= u_sample;
            step_reg <= step_size;
            z_reg    <= gate_value;
            cb_reg   <= coef_b;
            cc_reg   <= coef_c;
            last_reg <= step_last;
            if (kind == sss_pkg::KIND_LOAD && in_ok)
            begin
                a_tab[state_index] <= coef_a;
                b_tab[state_index] <= coef_b;
                c_tab[state_index] <= coef_c;
            end
        end
    end

    // Advance the arithmetic steps
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sss_pkg::OP_DT:
            begin
                dt_reg <= dt_next;
                av_reg <= a_tab[idx_reg];
                bv_reg <= cfg.input_coef_b ? cb_reg : b_tab[idx_reg];
                cv_reg <= cfg.input_coef_c ? cc_reg : c_tab[idx_reg];
            end
            sss_pkg::OP_MA:   p_reg    <= p_next;
            sss_pkg::OP_MQ:   q_reg    <= q_next;
            sss_pkg::OP_EXP:  e_reg    <= e_next;
            sss_pkg::OP_DB:   dtb_reg  <= dtb_next;
            sss_pkg::OP_DBU:  dbu_reg  <= dbu_next;
            sss_pkg::OP_EX:   ex_reg   <= ex_next;
            sss_pkg::OP_XN:   x_reg    <= x_next;
            sss_pkg::OP_XC:   xc_reg   <= xc_next;
            sss_pkg::OP_SKP:  gu_reg   <= gu_next;
            sss_pkg::OP_YS:   y_reg    <= ys_next;
            sss_pkg::OP_SIG:  sg_reg   <= sg_next;
            sss_pkg::OP_SILU: silu_reg <= silu_next;
            sss_pkg::OP_GATE: y_reg    <= gate_next;
            default:          ;
        endcase
    end

    // Hidden state and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sss_pkg::STATE_SIZE; i++)
                hs_reg[i] <= '0;
            sum_reg <= '0;
        end
        else if (in_acc && kind == sss_pkg::KIND_CLEAR)
        begin
            for (int i = 0; i < sss_pkg::STATE_SIZE; i++)
                hs_reg[i] <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.op == sss_pkg::OP_XN)
                hs_reg[idx_reg] <= x_next;
            if (cmd.op == sss_pkg::OP_ACC)
                sum_reg <= acc_next;
            else if (cmd.op == sss_pkg::OP_YS)
                sum_reg <= '0;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit && out_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && out_ready)
            out_value_reg <= y_reg;
    end

endmodule

// ===== sv/selective_state_space_scan.sv =====
// Top level of the selective state-space scan: configuration registers,
// sequencer and datapath. Depends on sss_pkg, sss_cfg, sss_ctrl, sss_dp.
//
// One item is taken at a time; clear and load items do not leave idle. A scan
// element with an in-range index runs a chain of ten registered steps after
// its accept (step size, dt*A, exponent, 2^q, dt*B, *u, decay, state write,
// *C, accumulate); the element that closes a time step then adds the
// feedthrough, output and emit steps, with sigmoid, SiLU and gate steps
// before emit when the gate is enabled, and emit waits while the previous
// result is not yet taken. The chain of dependent multiplies sets its length.
module selective_state_space_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [3:0]         state_index,
    input  logic signed [15:0] u_sample,
    input  logic signed [15:0] step_size,
    input  logic signed [15:0] gate_value,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    input  logic               step_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    sss_pkg::cfg_t    cfg;
    sss_pkg::cmd_t    cmd;
    sss_pkg::status_t status;
    logic             in_acc;

    assign in_acc = in_valid && !in_stall;

    sss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    sss_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .in_acc      (in_acc),
        .kind        (kind),
        .state_index (state_index),
        .u_sample    (u_sample),
        .step_size   (step_size),
        .gate_value  (gate_value),
        .coef_a      (coef_a),
        .coef_b      (coef_b),
        .coef_c      (coef_c),
        .step_last   (step_last),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value)
    );

    // A clear or load item never produces a result
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind != sss_pkg::KIND_SCAN && !out_valid) |=> !out_valid)
        else $error("result raised by a clear or load item");

    // A closing scan element keeps the input side busy
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind == sss_pkg::KIND_SCAN && step_last) |=> in_stall)
        else $error("input taken while a result is being formed");

    // A result only appears at the end of a busy sequence
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a busy sequence");

endmodule
